/* design/rcrp_pkg.sv */
// Package for the rack-constrained random placement core.
// Field widths, configuration register indexes, reset values and the
// request/status structs of the serial divider. No dependencies.
package rcrp_pkg;

  localparam int unsigned WORD_W    = 31;  // random word
  localparam int unsigned CFG_W     = 6;   // every configuration register
  localparam int unsigned CFG_IDX_W = 4;   // configuration register index
  localparam int unsigned NODE_O_W  = 5;   // placed_node port
  localparam int unsigned SLOT_W    = 5;   // chunk_slot port and slot counter
  localparam int unsigned STEP_W    = 5;   // divider step count

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT        = 4'd0,
    CFG_NODES_PER_RACK    = 4'd1,
    CFG_CHUNKS_PER_STRIPE = 4'd2,
    CFG_MAX_PER_RACK      = 4'd3
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST        = 6'd20;
  localparam logic [CFG_W-1:0] NODES_PER_RACK_RST    = 6'd4;
  localparam logic [CFG_W-1:0] CHUNKS_PER_STRIPE_RST = 6'd17;
  localparam logic [CFG_W-1:0] MAX_PER_RACK_RST      = 6'd5;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } sdiv_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sdiv_sts_t;

endpackage

/* design/rack_constrained_random_placement_core.sv */
// Top level of the rack-constrained random placement core: pool memory,
// rack counters, sequencer and output register. Depends on rcrp_pkg and
// rcrp_serdiv.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+----------------------------------------
//   input    | in_valid_i / in_stall_o  | random_word_i
//   output   | out_valid_o / out_stall_i| placed_node_o, chunk_slot_o, last_of_stripe_o
//   config   | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item at a time. An item passes through serial modulo in the shared
// divider, a pool read, serial rack division, then rack check, swap and
// output load; the input is freed once the result is loaded into the output
// register. A rejected draw ends after the rack check with no result and frees
// the input. The output register lets the next item start while a result is
// still stalled; an item whose result finds that register full waits in place.
// Reset clears the pool valid bits and rack counters at once; no clearing pass
// is needed.
module rack_constrained_random_placement_core import rcrp_pkg::*; #(
  parameter int unsigned MAX_NODES = 32,
  parameter int unsigned MAX_RACKS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WORD_W-1:0]    random_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [NODE_O_W-1:0]  placed_node_o,
  output logic [SLOT_W-1:0]    chunk_slot_o,
  output logic                 last_of_stripe_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned FW = $clog2(MAX_NODES + 1);
  localparam int unsigned VW = (FW > CFG_W) ? FW : CFG_W;
  localparam int unsigned RW = (MAX_RACKS > 1) ? $clog2(MAX_RACKS) : 1;
  localparam int unsigned FreeRstInt =
    (int'(NODE_COUNT_RST) > MAX_NODES) ? MAX_NODES : int'(NODE_COUNT_RST);
  localparam logic [FW-1:0] FREE_RST = FW'(FreeRstInt);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MOD  = 8'b0000_0010,
    S_NODE = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_TEST = 8'b0001_0000,
    S_SWAP = 8'b0010_0000,
    S_OUT  = 8'b0100_0000,
    S_RSV  = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;

  logic [CFG_W-1:0]  node_count_q, per_rack_q, chunks_q, max_rack_q;
  logic [FW-1:0]     free_left_q;
  logic [SLOT_W-1:0] next_slot_q;
  logic              vld_q [MAX_NODES];
  logic [CFG_W-1:0]  usage_q [MAX_RACKS];
  logic              out_valid_q;

  logic [NW-1:0]     mem_q [MAX_NODES];
  logic [NW-1:0]     rd_q, rd_idx_q;
  logic              rdv_q;
  logic [NW-1:0]     pick_q, node_q;
  logic [RW-1:0]     rack_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic              res_last_q;
  logic [NODE_O_W-1:0] out_node_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_last_q;

  sdiv_req_t         div_req;
  sdiv_sts_t         div_sts;
  logic [WORD_W-1:0] div_dividend, div_quot;
  logic [VW-1:0]     div_divisor, div_rem;

  logic              in_acc, cfg_we, out_load, restart;
  logic [FW-1:0]     free_m1, restart_free;
  logic [NW-1:0]     rd_addr, rd_val;
  logic [CFG_W-1:0]  per_eff;
  logic [NW-1:0]     q_node;
  logic [RW-1:0]     rack_w;
  logic              reject, last_w;

  function automatic logic [FW-1:0] eff_nodes(logic [CFG_W-1:0] n);
    eff_nodes = (32'(n) > MAX_NODES) ? FW'(MAX_NODES) : FW'(n);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign free_m1 = free_left_q - FW'(1);
  assign per_eff = (per_rack_q == '0) ? CFG_W'(1) : per_rack_q;
  assign rd_val  = rdv_q ? rd_q : rd_idx_q;  // never written: entry holds its index
  assign q_node  = div_quot[NW-1:0];
  assign rack_w  = (32'(q_node) > MAX_RACKS - 1) ? RW'(MAX_RACKS - 1) : RW'(q_node);
  assign reject  = (usage_q[rack_q] >= max_rack_q);
  assign last_w  = ((7'(next_slot_q) + 7'd1) >= 7'(chunks_q)) || (free_left_q == FW'(1));

  // read the pick on modulo completion, the tail entry on a passing rack check
  assign rd_addr = (state_q == S_TEST) ? free_m1[NW-1:0] : div_rem[NW-1:0];

  // divider: modulo by pool size first, then node divided by rack width
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = STEP_W'(WORD_W);
    div_dividend  = random_word_i;
    div_divisor   = VW'(free_left_q);
    if (state_q == S_NODE || state_q == S_DIV) begin
      div_divisor = VW'(per_eff);
    end
    if (state_q == S_IDLE) begin
      div_req.start = in_acc && (free_left_q != '0);
    end else if (state_q == S_NODE) begin
      div_req.start = 1'b1;
      div_req.steps = STEP_W'(NW);
      div_dividend  = WORD_W'(rd_val) << (WORD_W - NW);
    end
  end

  rcrp_serdiv #(
    .VW (VW)
  ) u_serdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (div_req.start) state_d = S_MOD;
      S_MOD:  if (div_sts.done) state_d = S_NODE;
      S_NODE: state_d = S_DIV;
      S_DIV:  if (div_sts.done) state_d = S_TEST;
      S_TEST: state_d = reject ? S_IDLE : S_SWAP;
      S_SWAP: state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    restart      = 1'b0;
    restart_free = eff_nodes(node_count_q);
    if (cfg_we && cfg_index_i == CFG_NODE_COUNT) begin
      restart      = 1'b1;
      restart_free = eff_nodes(cfg_data_i);
    end else if (state_q == S_SWAP && last_w) begin
      restart = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= NODE_COUNT_RST;
      per_rack_q   <= NODES_PER_RACK_RST;
      chunks_q     <= CHUNKS_PER_STRIPE_RST;
      max_rack_q   <= MAX_PER_RACK_RST;
      free_left_q  <= FREE_RST;
      next_slot_q  <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < MAX_NODES; i++) vld_q[i] <= 1'b0;
      for (int i = 0; i < MAX_RACKS; i++) usage_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        unique case (cfg_index_i)
          CFG_NODE_COUNT:        node_count_q <= cfg_data_i;
          CFG_NODES_PER_RACK:    per_rack_q   <= cfg_data_i;
          CFG_CHUNKS_PER_STRIPE: chunks_q     <= cfg_data_i;
          CFG_MAX_PER_RACK:      max_rack_q   <= cfg_data_i;
          default: ;  // drop writes beyond the register list
        endcase
      end
      if (restart) begin
        for (int i = 0; i < MAX_NODES; i++) vld_q[i] <= 1'b0;
        for (int i = 0; i < MAX_RACKS; i++) usage_q[i] <= '0;
        free_left_q <= restart_free;
        next_slot_q <= '0;
      end else if (state_q == S_SWAP) begin
        vld_q[pick_q]   <= 1'b1;
        usage_q[rack_q] <= usage_q[rack_q] + CFG_W'(1);
        free_left_q     <= free_m1;
        next_slot_q     <= next_slot_q + SLOT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q     <= mem_q[rd_addr];
    rdv_q    <= vld_q[rd_addr];
    rd_idx_q <= rd_addr;
    if (state_q == S_MOD && div_sts.done) pick_q <= div_rem[NW-1:0];
    if (state_q == S_NODE) node_q <= rd_val;
    if (state_q == S_DIV && div_sts.done) rack_q <= rack_w;
    if (state_q == S_SWAP) begin
      // move the tail entry into the picked slot
      mem_q[pick_q] <= rd_val;
      res_slot_q    <= next_slot_q;
      res_last_q    <= last_w;
    end
    if (out_load) begin
      out_node_q <= NODE_O_W'(node_q);
      out_slot_q <= res_slot_q;
      out_last_q <= res_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign placed_node_o    = out_node_q;
  assign chunk_slot_o     = out_slot_q;
  assign last_of_stripe_o = out_last_q;

  a_swap_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWAP |-> (FW'(pick_q) < free_left_q))
    else $error("picked slot lies outside the free pool");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == S_MOD || state_q == S_DIV))
    else $error("divider finished outside a wait state");

  a_accept_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !div_sts.busy)
    else $error("input transfer while the divider is busy");

  a_out_after_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && !$past(state_q == S_OUT) |-> $past(state_q == S_SWAP))
    else $error("result raised without a pool swap");

endmodule

/* design/rcrp_serdiv.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Dividend enters left-aligned; after N steps the low N bits hold the
// quotient. Depends on rcrp_pkg.
module rcrp_serdiv import rcrp_pkg::*; #(
  parameter int unsigned VW = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdiv_req_t         req_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [VW-1:0]     divisor_i,
  output sdiv_sts_t         sts_o,
  output logic [WORD_W-1:0] quot_o,
  output logic [VW-1:0]     rem_o
);

  logic [WORD_W-1:0] sh_q;
  logic [VW-1:0]     rem_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [VW:0]       trial, diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, sh_q[WORD_W-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = (trial >= {1'b0, divisor_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // shift the quotient bit in from the right as the dividend leaves
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[WORD_W-2:0], ge};
      rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = sh_q;
  assign rem_o      = rem_q;

endmodule
